@@ sv/nus_pkg.sv @@
// Shared types and constants for the Annex B NAL unit splitter.
// No dependencies; used by the parser, the result queue, the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

package nus_pkg;

   typedef enum logic [1:0] {
      KIND_NAL      = 2'd0,
      KIND_EMPTY    = 2'd1,
      KIND_NO_NAL   = 2'd2,
      KIND_OVERFLOW = 2'd3
   } rec_kind_type;

   typedef struct packed {
      rec_kind_type kind;
      logic [15:0]  nal_offset;
      logic [16:0]  nal_length;
      logic [4:0]   nal_kind;
      logic         key_unit;
      logic         final_nal;
      logic         last_record;
   } record_type;

   typedef struct packed {
      logic       valid;
      record_type rec;
   } slot_type;

   localparam logic [7:0] BYTE_ZERO = 8'h00;
   localparam logic [7:0] BYTE_ONE  = 8'h01;
   localparam logic [4:0] TYPE_IDR  = 5'd5;
   localparam logic [4:0] TYPE_SPS  = 5'd7;
   localparam logic [4:0] TYPE_PPS  = 5'd8;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   function automatic logic is_key(input logic [4:0] t);
      return (t == TYPE_IDR) || (t == TYPE_SPS) || (t == TYPE_PPS);
   endfunction

   function automatic record_type make_nal(input logic [15:0] off, input logic [16:0] len,
                                           input logic [4:0] t, input logic fin);
      record_type r;
      r.kind        = KIND_NAL;
      r.nal_offset  = off;
      r.nal_length  = len;
      r.nal_kind    = t;
      r.key_unit    = is_key(t);
      r.final_nal   = fin;
      r.last_record = 1'b0;
      return r;
   endfunction

   function automatic record_type make_flag(input rec_kind_type k);
      record_type r;
      r             = '0;
      r.kind        = k;
      return r;
   endfunction

endpackage

`default_nettype wire

@@ sv/nus_parser.sv @@
// Start-code parser: per-unit state registers and the per-byte decode logic.
// Produces up to two record slots per accepted beat. Depends on nus_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nus_parser #(
   parameter int MAX_UNIT_LEN = 65536
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic [7:0]        data_byte,
   input  wire logic              unit_end,
   output nus_pkg::slot_type      slot0,
   output nus_pkg::slot_type      slot1
);

   localparam int POS_W = $clog2(MAX_UNIT_LEN + 1);
   localparam int EXT_W = (POS_W > 17) ? POS_W : 17;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [1:0]       zrun_ff, zrun_in;
   logic             open_ff, open_in;
   logic [POS_W-1:0] begin_ff, begin_in;
   logic [4:0]       cap_ff, cap_in;
   logic             halt_ff, halt_in;

   logic [POS_W-1:0] pos_nx;
   logic [POS_W-1:0] end_pos;
   logic [POS_W-1:0] fin_len;
   logic             over;
   logic             is_sc;
   logic             empty;
   logic             halt_now;
   nus_pkg::slot_type first_s, final_s;

   function automatic logic [15:0] to_off(input logic [POS_W-1:0] v);
      logic [EXT_W-1:0] w;
      w = EXT_W'(v);
      return w[15:0];
   endfunction

   function automatic logic [16:0] to_len(input logic [POS_W-1:0] v);
      logic [EXT_W-1:0] w;
      w = EXT_W'(v);
      return w[16:0];
   endfunction

   always_comb begin
      over     = (pos_ff >= POS_W'(MAX_UNIT_LEN));
      pos_nx   = pos_ff + POS_W'(1);
      is_sc    = (data_byte == nus_pkg::BYTE_ONE) && (zrun_ff >= 2'd2);
      end_pos  = pos_nx - ((zrun_ff == 2'd2) ? POS_W'(3) : POS_W'(4));
      empty    = (end_pos <= begin_ff);
      halt_now = over || (is_sc && open_ff && empty);

      // type comes from byte 0 before any start code, else from the first NAL byte
      cap_in = cap_ff;
      if ((!open_ff && pos_ff == '0) || (open_ff && pos_ff == begin_ff)) begin
         cap_in = data_byte[4:0];
      end

      zrun_in = 2'd0;
      if (data_byte == nus_pkg::BYTE_ZERO) begin
         zrun_in = (zrun_ff == 2'd3) ? 2'd3 : zrun_ff + 2'd1;
      end

      open_in  = open_ff | is_sc;
      begin_in = is_sc ? pos_nx : begin_ff;
      pos_in   = pos_nx;
      halt_in  = halt_now;
      fin_len  = pos_nx - begin_in;

      first_s = '0;
      if (over) begin
         first_s.valid = 1'b1;
         first_s.rec   = nus_pkg::make_flag(nus_pkg::KIND_OVERFLOW);
      end else if (is_sc && open_ff) begin
         first_s.valid = 1'b1;
         if (empty) begin
            first_s.rec = nus_pkg::make_flag(nus_pkg::KIND_EMPTY);
         end else begin
            first_s.rec = nus_pkg::make_nal(to_off(begin_ff), to_len(end_pos - begin_ff),
                                            cap_in, 1'b0);
         end
      end

      final_s = '0;
      if (unit_end && !halt_now) begin
         final_s.valid = 1'b1;
         if (!open_in) begin
            final_s.rec = nus_pkg::make_nal(16'd0, to_len(pos_nx), cap_in, 1'b1);
         end else if (fin_len == '0) begin
            final_s.rec = nus_pkg::make_flag(nus_pkg::KIND_NO_NAL);
         end else begin
            final_s.rec = nus_pkg::make_nal(to_off(begin_in), to_len(fin_len), cap_in, 1'b1);
         end
      end

      // pack the records in order; mark the later one as last of the beat
      slot0 = '0;
      slot1 = '0;
      if (accept && !halt_ff) begin
         if (first_s.valid) begin
            slot0 = first_s;
            slot1 = final_s;
            if (final_s.valid) begin
               slot1.rec.last_record = 1'b1;
            end else begin
               slot0.rec.last_record = 1'b1;
            end
         end else if (final_s.valid) begin
            slot0 = final_s;
            slot0.rec.last_record = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         zrun_ff  <= '0;
         open_ff  <= 1'b0;
         begin_ff <= '0;
         cap_ff   <= '0;
         halt_ff  <= 1'b0;
      end else if (accept) begin
         if (unit_end) begin
            pos_ff   <= '0;
            zrun_ff  <= '0;
            open_ff  <= 1'b0;
            begin_ff <= '0;
            cap_ff   <= '0;
            halt_ff  <= 1'b0;
         end else if (halt_ff) begin
            halt_ff <= 1'b1;
         end else if (over) begin
            halt_ff <= 1'b1;
         end else begin
            pos_ff   <= pos_in;
            zrun_ff  <= zrun_in;
            open_ff  <= open_in;
            begin_ff <= begin_in;
            cap_ff   <= cap_in;
            halt_ff  <= halt_in;
         end
      end
   end

endmodule

`default_nettype wire

@@ sv/nus_rsp_queue.sv @@
// Four-entry result queue: takes up to two records per cycle, delivers one per beat.
// Depends on nus_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nus_rsp_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire nus_pkg::slot_type    slot0,
   input  wire nus_pkg::slot_type    slot1,
   output logic                      room2,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output nus_pkg::record_type       out_rec
);

   nus_pkg::record_type mem_ff [nus_pkg::QUEUE_DEPTH];

   logic [nus_pkg::QPTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [nus_pkg::QCNT_W-1:0] cnt_ff, cnt_in;
   logic [nus_pkg::QCNT_W-1:0] n_push;
   logic                       pop;

   always_comb begin
      pop    = out_valid && out_ready;
      n_push = nus_pkg::QCNT_W'(slot0.valid) + nus_pkg::QCNT_W'(slot1.valid);
      wr_in  = wr_ff + n_push[nus_pkg::QPTR_W-1:0];
      rd_in  = rd_ff + nus_pkg::QPTR_W'(pop);
      cnt_in = cnt_ff + n_push - nus_pkg::QCNT_W'(pop);
   end

   assign room2     = (cnt_ff <= nus_pkg::QCNT_W'(nus_pkg::QUEUE_DEPTH - 2));
   assign out_valid = (cnt_ff != '0);
   assign out_rec   = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (slot0.valid) begin
         mem_ff[wr_ff] <= slot0.rec;
      end
      if (slot1.valid) begin
         mem_ff[wr_ff + nus_pkg::QPTR_W'(1)] <= slot1.rec;
      end
   end

endmodule

`default_nettype wire

@@ sv/annexb_nal_unit_splitter_core.sv @@
// Top level of the Annex B NAL unit splitter: byte stream in, NAL records out.
// Instantiates nus_parser and nus_rsp_queue; depends on nus_pkg.
//
//   channel | dir | tdata                                  | tuser       | tlast
//   req_    | in  | [7:0] data_byte                        | -           | unit_end
//   rsp_    | out | [15:0] offset [32:16] length           | record_kind | last_record
//           |     | [37:33] nal_kind [38] key [39] final   |             |
//
// One byte beat per cycle. A byte that closes a NAL on the last byte of a unit
// gives two records; the 4-entry result queue accepts a beat only with two free
// slots, so sustained two-record beats pace input to the rsp_ drain rate.
// Results leave the queue the cycle after the byte is taken, at the earliest.
// Synchronous reset clears parser state and the queue.
`timescale 1ns / 1ps
`default_nettype none

module annexb_nal_unit_splitter_core #(
   parameter int MAX_UNIT_LEN = 65536
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic        req_tlast,   // unit_end
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // nal_offset, nal_length, nal_kind, key_unit, final_nal
   output logic [1:0]       rsp_tuser,   // record_kind
   output logic             rsp_tlast    // last_record
);

   nus_pkg::slot_type   slot0, slot1;
   nus_pkg::record_type out_rec;
   logic                room2;
   logic                accept;

   assign req_tready = room2;
   assign accept     = req_tvalid && room2;

   nus_parser #(
      .MAX_UNIT_LEN(MAX_UNIT_LEN)
   ) u_parser (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .data_byte(req_tdata),
      .unit_end (req_tlast),
      .slot0    (slot0),
      .slot1    (slot1)
   );

   nus_rsp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .slot0    (slot0),
      .slot1    (slot1),
      .room2    (room2),
      .out_valid(rsp_tvalid),
      .out_ready(rsp_tready),
      .out_rec  (out_rec)
   );

   assign rsp_tdata = {out_rec.final_nal, out_rec.key_unit, out_rec.nal_kind,
                       out_rec.nal_length, out_rec.nal_offset};
   assign rsp_tuser = out_rec.kind;
   assign rsp_tlast = out_rec.last_record;

endmodule

`default_nettype wire

@@ sv/nus_checker.sv @@
// Port-level checker for the NAL unit splitter, bound to the top level.
// Depends on nus_pkg and annexb_nal_unit_splitter_core.
`timescale 1ns / 1ps
`default_nettype none

module nus_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [39:0] rsp_tdata,
   input wire logic [1:0]  rsp_tuser,
   input wire logic        rsp_tlast
);

   // hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result beat dropped while stalled");

   a_flag_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != nus_pkg::KIND_NAL |-> rsp_tdata == 40'd0)
      else $error("non-NAL record carries payload fields");

   a_flag_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != nus_pkg::KIND_NAL |-> rsp_tlast)
      else $error("non-NAL record not last of its beat");

   a_key_type: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[38] |->
         (rsp_tdata[37:33] == nus_pkg::TYPE_IDR) || (rsp_tdata[37:33] == nus_pkg::TYPE_SPS)
         || (rsp_tdata[37:33] == nus_pkg::TYPE_PPS))
      else $error("key flag on a non-key NAL type");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind annexb_nal_unit_splitter_core nus_checker u_nus_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tuser (rsp_tuser),
   .rsp_tlast (rsp_tlast)
);

`default_nettype wire
